[design/mbps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

    // Signature storage and register port geometry.
    localparam int SIG_BYTES       = 32;
    localparam int SIG_IDX_W       = $clog2(SIG_BYTES);
    localparam int SIG_WORDS       = 4;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int LEN_W           = 6;
    localparam int SKIP_W          = 16;
    localparam int OFFSET_W        = 32;
    localparam int ADDR_W          = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_CARE_MASK = 3'd4,
        CFG_PAT_LEN   = 3'd5,
        CFG_SKIP      = 3'd6,
        CFG_BASE      = 3'd7
    } t_cfg_idx;

    typedef logic [7:0] t_byte;

endpackage

`default_nettype wire

[design/masked_byte_pattern_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none
// An item taken from the input stream sits in the input register; its result, if any, is
// loaded into the output register when the pipe advances; the window compare is done there.
// Throughput: one byte per cycle when the output is not stalled; the full-window compare is a
// parallel AND of byte compares. Reset (synchronous, active low) clears the configuration
// registers, the valid flags, the window position, the match count and the report flag; the
// window bytes need no clearing since only filled entries are compared.
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] data_byte
    input  logic                              i_s_tlast,
    // Result stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [mbps_pkg::ADDR_W-1:0]       o_m_tdata,   // [63:0] match_address
    output logic                              o_m_tuser    // [0] found
);
    import mbps_pkg::*;

    localparam int WinDepth = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;

    // Configuration registers.
    logic [SIG_WORDS-1:0][CFG_DATA_W-1:0] r_pat_words;
    logic [SIG_BYTES-1:0]                 r_care;
    logic [LEN_W-1:0]                     r_len;
    logic [SKIP_W-1:0]                    r_skip;
    logic [ADDR_W-1:0]                    r_base;
    logic [SIG_BYTES-1:0][7:0]            w_sig;

    // Signature aligned to window positions.
    t_byte                                r_exp_byte [WinDepth];
    t_byte                                n_exp_byte [WinDepth];
    logic [WinDepth-1:0]                  r_exp_care;
    logic [WinDepth-1:0]                  n_exp_care;
    logic                                 r_len_ok;
    logic                                 n_len_ok;

    // Input register.
    logic                                 r_s1_valid;
    t_byte                                r_s1_byte;
    logic                                 r_s1_last;

    // Region state.
    t_byte                                r_window [WinDepth];
    t_byte                                n_window [WinDepth];
    logic [OFFSET_W-1:0]                  r_offset;
    logic [OFFSET_W-1:0]                  n_offset;
    logic [SKIP_W-1:0]                    r_passed;
    logic                                 r_reported;

    // Output register.
    logic                                 r_out_valid;
    logic                                 r_found;
    logic [ADDR_W-1:0]                    r_addr;

    logic                                 w_advance;
    logic                                 w_proc;
    logic                                 w_exact;
    logic [WinDepth-1:0]                  w_hit;
    logic                                 w_cond;
    logic                                 w_report;
    logic [OFFSET_W-1:0]                  w_start;

    assign o_cfg_ready = 1'b1;
    assign w_sig       = r_pat_words;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_words <= '0;
            r_care      <= '0;
            r_len       <= '0;
            r_skip      <= '0;
            r_base      <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_0_7:   r_pat_words[0] <= i_cfg_data;
                CFG_PAT_8_15:  r_pat_words[1] <= i_cfg_data;
                CFG_PAT_16_23: r_pat_words[2] <= i_cfg_data;
                CFG_PAT_24_31: r_pat_words[3] <= i_cfg_data;
                CFG_CARE_MASK: r_care         <= i_cfg_data[SIG_BYTES-1:0];
                CFG_PAT_LEN:   r_len          <= i_cfg_data[LEN_W-1:0];
                CFG_SKIP:      r_skip         <= i_cfg_data[SKIP_W-1:0];
                CFG_BASE:      r_base         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Window position k holds the byte that signature byte len-1-k is compared with.
    always_comb begin
        logic [LEN_W-1:0] idx;
        logic             in_use;
        for (int k = 0; k < WinDepth; k++) begin
            idx           = r_len - LEN_W'(1) - LEN_W'(k);
            in_use        = LEN_W'(k) < r_len;
            n_exp_byte[k] = w_sig[idx[SIG_IDX_W-1:0]];
            n_exp_care[k] = in_use && r_care[idx[SIG_IDX_W-1:0]];
        end
        n_len_ok = (r_len != '0) && (r_len <= LEN_W'(WinDepth));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_care <= '0;
            r_len_ok   <= 1'b0;
        end else begin
            r_exp_care <= n_exp_care;
            r_len_ok   <= n_len_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp_byte <= n_exp_byte;
    end

    // Handshake: the whole pipe moves when the output register is free.
    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_advance;
    assign w_proc     = r_s1_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_s1_byte <= i_s_tdata;
            r_s1_last <= i_s_tlast;
        end
    end

    // Shifted window and saturating position.
    always_comb begin
        n_window[0] = r_s1_byte;
        for (int k = 1; k < WinDepth; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    assign w_exact  = r_offset != '1;
    assign n_offset = w_exact ? r_offset + OFFSET_W'(1) : r_offset;

    // Masked compare over the aligned window.
    always_comb begin
        for (int k = 0; k < WinDepth; k++) begin
            w_hit[k] = !r_exp_care[k] || (n_window[k] == r_exp_byte[k]);
        end
    end

    assign w_cond   = !r_reported && w_exact && r_len_ok &&
                      (n_offset >= OFFSET_W'(r_len)) && (&w_hit);
    assign w_report = w_cond && (r_passed >= r_skip);
    assign w_start  = n_offset - OFFSET_W'(r_len);

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_window <= n_window;
        end
    end

    // Region state; the final byte returns it to its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_passed   <= '0;
            r_reported <= 1'b0;
        end else if (w_proc) begin
            if (r_s1_last) begin
                r_offset   <= '0;
                r_passed   <= '0;
                r_reported <= 1'b0;
            end else begin
                r_offset <= n_offset;
                if (w_cond && !w_report) begin
                    r_passed <= r_passed + SKIP_W'(1);
                end
                if (w_report) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    // Output register: a match, or not-found at the end of a region without a report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_proc && (w_report || (r_s1_last && !r_reported));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_found <= w_report;
            r_addr  <= w_report ? r_base + ADDR_W'(w_start) : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_addr;
    assign o_m_tuser  = r_found;

    // A not-found item carries a zero address.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_addr == '0))
        else $error("not-found item with nonzero address");

    // After a report, a byte that does not end the region produces nothing.
    a_no_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_reported && !r_s1_last) |=> !r_out_valid)
        else $error("item produced after a report");

    // A region that ends without a report yields an item.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_s1_last && !r_reported) |=> r_out_valid)
        else $error("region ended without a result");

    // The end of a region clears its state.
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_s1_last) |=> (r_offset == '0 && r_passed == '0 && !r_reported))
        else $error("region state not cleared");

endmodule

`default_nettype wire
